// ----- rtl/rbpm_pkg.sv -----
// Shared types, constants and helpers for the ring buffer pointer manager.
// No dependencies; imported by the top level, its checker and the testbench.
package rbpm_pkg;

  localparam int MAX_SLOTS = 4096;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // Operation codes
  localparam logic [2:0] FUNC_ADVANCE = 3'd0;
  localparam logic [2:0] FUNC_SKIP    = 3'd1;
  localparam logic [2:0] FUNC_GET     = 3'd2;
  localparam logic [2:0] FUNC_SET     = 3'd3;
  localparam logic [2:0] FUNC_DIFF    = 3'd4;
  localparam logic [2:0] FUNC_HOME    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWNWARD = 2'd1;

  typedef struct packed {
    logic [2:0]       func;
    logic             which_side;
    logic [CNT_W-1:0] amount;
    logic             backward;
    logic [IDX_W-1:0] index_in;
    logic             index_in_valid;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_out;
    logic             index_out_valid;
    logic [CNT_W-1:0] occupancy;
    logic [CNT_W-1:0] difference;
    logic             bigger;
  } res_t;

  // Capacity as used: zero acts as one, anything above the maximum saturates.
  function automatic logic [CNT_W-1:0] cap_eff(input logic [CFG_DAT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CFG_DAT_W'(MAX_SLOTS)) begin
      r = CNT_W'(MAX_SLOTS);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  // Slots between start and end; equal indices count as a full ring.
  function automatic logic [CNT_W-1:0] span(input logic [IDX_W-1:0] s,
                                            input logic [IDX_W-1:0] e,
                                            input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (e > s) begin
      r = CNT_W'(e) - CNT_W'(s);
    end else begin
      r = c - CNT_W'(s) + CNT_W'(e);
    end
    return r;
  endfunction

endpackage

// ----- rtl/ring_buffer_pointer_manager.sv -----
// Ring buffer pointer manager: start/end indices, empty flag, capacity and direction.
// Depends on rbpm_pkg.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------
//   cmd      | in        | cmd_valid/ready    | cmd_t (one operation)
//   res      | out       | res_valid/ready    | res_t (one result per cmd)
//   cfg      | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// One item per cycle while results are taken; each item passes the command register,
// then the result register. The pointer state is updated in the cycle the command
// register hands its item to the result register, unless a cfg write overrides it.
// Reset is synchronous on rst and leaves capacity 4096, upward, empty. A stalled
// result holds the result register, which holds the command register.
module ring_buffer_pointer_manager
  import rbpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic                 q_valid;
  cmd_t                 q_item;
  logic                 advance;

  logic [CFG_DAT_W-1:0] capacity;
  logic                 downward;
  logic [IDX_W-1:0]     start_index, start_index_next;
  logic [IDX_W-1:0]     end_index, end_index_next;
  logic                 is_empty, is_empty_next;
  res_t                 res_next;

  logic [CNT_W-1:0]     cap;
  logic [CNT_W-1:0]     size;
  logic                 uses_start;
  logic [IDX_W-1:0]     sp, sp_step, rp, rp_new, home, clamped;
  logic                 ok;
  logic [CNT_W-1:0]     x, fr, q, size2;
  logic [IDX_W-1:0]     s2, e2;

  logic                 cfg_hit;
  logic [CNT_W-1:0]     cap_new;
  logic                 down_new;
  logic [IDX_W-1:0]     home_new;

  assign advance   = q_valid && (!res_valid || res_ready);
  assign cmd_ready = !q_valid || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    cap        = cap_eff(capacity);
    size       = is_empty ? '0 : span(start_index, end_index, cap);
    uses_start = downward != q_item.which_side;
    sp         = uses_start ? start_index : end_index;
    rp         = downward ? end_index : start_index;
    home       = downward ? IDX_W'(cap - CNT_W'(1)) : '0;
    clamped    = (CNT_W'(q_item.index_in) >= cap) ? IDX_W'(cap - CNT_W'(1))
                                                  : q_item.index_in;

    if (downward) begin
      sp_step = (sp == '0) ? IDX_W'(cap - CNT_W'(1)) : sp - IDX_W'(1);
    end else begin
      sp_step = (CNT_W'(sp) + CNT_W'(1) >= cap) ? '0 : sp + IDX_W'(1);
    end

    ok = q_item.which_side ? (size != '0) : (size < cap);

    // Skip amount after clamping to the free space or to the occupancy
    fr = cap - size;
    x  = q_item.amount;
    if (q_item.backward) begin
      if (x > fr) x = fr;
    end else if (x >= size) begin
      x = size;
    end
    q = cap - CNT_W'(rp);
    if (q_item.backward != downward) begin
      rp_new = (CNT_W'(rp) < x) ? IDX_W'(cap - x + CNT_W'(rp)) : IDX_W'(CNT_W'(rp) - x);
    end else begin
      rp_new = (q <= x) ? IDX_W'(x - q) : IDX_W'(CNT_W'(rp) + x);
    end

    s2    = uses_start ? clamped : start_index;
    e2    = uses_start ? end_index : clamped;
    size2 = span(s2, e2, cap);

    start_index_next = start_index;
    end_index_next   = end_index;
    is_empty_next    = is_empty;
    res_next         = '0;

    case (q_item.func)
      FUNC_ADVANCE: begin
        if (ok) begin
          res_next.index_out       = sp;
          res_next.index_out_valid = 1'b1;
          if (q_item.which_side) begin
            if (size == CNT_W'(1)) is_empty_next = 1'b1;
          end else begin
            is_empty_next = 1'b0;
          end
          if (uses_start) start_index_next = sp_step;
          else end_index_next = sp_step;
        end
      end
      FUNC_SKIP: begin
        if (q_item.amount != '0) begin
          if (q_item.backward) is_empty_next = 1'b0;
          else if (q_item.amount >= size) is_empty_next = 1'b1;
          if (downward) end_index_next = rp_new;
          else start_index_next = rp_new;
        end
      end
      FUNC_GET: begin
        if (!is_empty) begin
          res_next.index_out       = sp;
          res_next.index_out_valid = 1'b1;
        end
      end
      FUNC_SET: begin
        if (!q_item.index_in_valid) begin
          is_empty_next    = 1'b1;
          start_index_next = home;
          end_index_next   = home;
        end else if (uses_start) begin
          start_index_next = clamped;
        end else begin
          end_index_next = clamped;
        end
      end
      FUNC_DIFF: begin
        if (!q_item.index_in_valid) begin
          res_next.difference = size;
        end else if (size2 > size) begin
          res_next.bigger     = 1'b1;
          res_next.difference = size2 - size;
        end else begin
          res_next.difference = size - size2;
        end
      end
      FUNC_HOME: begin
        start_index_next = home;
        end_index_next   = home;
      end
      default: begin
      end
    endcase

    res_next.occupancy = is_empty_next ? '0
                                       : span(start_index_next, end_index_next, cap);
  end

  // Home position under the values a configuration write leaves behind
  always_comb begin
    cfg_hit  = (cfg_index == CFG_CAPACITY) || (cfg_index == CFG_DOWNWARD);
    cap_new  = cap_eff((cfg_index == CFG_CAPACITY) ? cfg_data : capacity);
    down_new = (cfg_index == CFG_DOWNWARD) ? cfg_data[0] : downward;
    home_new = down_new ? IDX_W'(cap_new - CNT_W'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid     <= 1'b0;
      res_valid   <= 1'b0;
      capacity    <= CFG_DAT_W'(MAX_SLOTS);
      downward    <= 1'b0;
      start_index <= '0;
      end_index   <= '0;
      is_empty    <= 1'b1;
    end else begin
      if (cmd_valid && cmd_ready) begin
        q_valid <= 1'b1;
      end else if (advance) begin
        q_valid <= 1'b0;
      end

      if (advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_valid && cfg_hit) begin
        if (cfg_index == CFG_CAPACITY) capacity <= cfg_data;
        else downward <= cfg_data[0];
        is_empty    <= 1'b1;
        start_index <= home_new;
        end_index   <= home_new;
      end else if (advance) begin
        is_empty    <= is_empty_next;
        start_index <= start_index_next;
        end_index   <= end_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) q_item <= cmd;
    if (advance) res <= res_next;
  end

endmodule

// ----- rtl/rbpm_checker.sv -----
// Port-level checks for the ring buffer pointer manager, bound to the top level.
// Depends on rbpm_pkg.
module rbpm_checker
  import rbpm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_no_res_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result shown right after reset");

  a_index_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.index_out_valid |-> res.index_out == '0)
    else $error("index shown without its valid flag");

  a_bigger_diff: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bigger |-> res.difference != '0 && !res.index_out_valid)
    else $error("bigger flag with zero difference");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.occupancy <= CNT_W'(MAX_SLOTS)
               && res.difference <= CNT_W'(MAX_SLOTS))
    else $error("occupancy or difference beyond the ring size");

endmodule

bind ring_buffer_pointer_manager rbpm_checker u_rbpm_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for ring_buffer_pointer_manager: directed corner cases,
// then random streams over a sweep of capacity and direction, and a steady stream.
// Depends on rbpm_pkg and the top level; results are checked against an in-bench predictor.
module testbench;
  import rbpm_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int STALL_LIMIT = 2000;

  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;
  localparam logic WRITE_SIDE = 1'b0;
  localparam logic READ_SIDE  = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t op_item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Pointer state as the block should hold it
  logic [CFG_DAT_W-1:0] reg_capacity = CFG_DAT_W'(MAX_SLOTS);
  logic reg_downward = 1'b0;
  logic [IDX_W-1:0] ring_start = '0;
  logic [IDX_W-1:0] ring_end = '0;
  logic ring_empty = 1'b1;

  res_t pointer_replies[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit steady_flow = 1'b0;
  int write_pct = 50;

  ring_buffer_pointer_manager DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(op_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int slots_in_use();
    if (reg_capacity == '0) return 1;
    if (reg_capacity > CFG_DAT_W'(MAX_SLOTS)) return MAX_SLOTS;
    return int'(reg_capacity);
  endfunction

  function automatic void send_home();
    int h;
    h = reg_downward ? slots_in_use() - 1 : 0;
    ring_start = IDX_W'(h);
    ring_end = IDX_W'(h);
  endfunction

  // Equal indices count as a full ring
  function automatic int ring_span(input int s, input int e);
    return (e > s) ? e - s : slots_in_use() - s + e;
  endfunction

  function automatic int fill_level();
    return ring_empty ? 0 : ring_span(int'(ring_start), int'(ring_end));
  endfunction

  function automatic void put_side_ptr(input bit on_start, input int p);
    if (on_start) ring_start = IDX_W'(p);
    else ring_end = IDX_W'(p);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_CAPACITY: begin
        reg_capacity = data;
        ring_empty = 1'b1;
        send_home();
      end
      CFG_DOWNWARD: begin
        reg_downward = data[0];
        ring_empty = 1'b1;
        send_home();
      end
      default: ;
    endcase
  endfunction

  function automatic res_t run_pointer_op(input cmd_t c);
    res_t r;
    int cap, size, size2, x, p, fr, v, s, e;
    bit on_start;
    r = '0;
    cap = slots_in_use();
    on_start = (reg_downward != c.which_side);
    p = on_start ? int'(ring_start) : int'(ring_end);
    v = (int'(c.index_in) >= cap) ? cap - 1 : int'(c.index_in);
    case (c.func)
      FUNC_ADVANCE: begin
        size = fill_level();
        if (c.which_side ? (size != 0) : (size < cap)) begin
          r.index_out = IDX_W'(p);
          r.index_out_valid = 1'b1;
          if (c.which_side) begin
            if (size == 1) ring_empty = 1'b1;
          end else begin
            ring_empty = 1'b0;
          end
          if (reg_downward) p = (p == 0) ? cap - 1 : p - 1;
          else p = (p + 1 >= cap) ? 0 : p + 1;
          put_side_ptr(on_start, p);
        end
      end
      FUNC_SKIP: begin
        if (c.amount != '0) begin
          size = fill_level();
          x = int'(c.amount);
          p = reg_downward ? int'(ring_end) : int'(ring_start);
          // clamp to free space going back, to the fill level going forward
          if (c.backward) begin
            fr = cap - size;
            if (x > fr) x = fr;
            ring_empty = 1'b0;
          end else if (x >= size) begin
            x = size;
            ring_empty = 1'b1;
          end
          if (c.backward != reg_downward) p = (p < x) ? cap - x + p : p - x;
          else p = (cap - p <= x) ? x - (cap - p) : p + x;
          put_side_ptr(!reg_downward, p);
        end
      end
      FUNC_GET: begin
        if (!ring_empty) begin
          r.index_out = IDX_W'(p);
          r.index_out_valid = 1'b1;
        end
      end
      FUNC_SET: begin
        if (!c.index_in_valid) begin
          ring_empty = 1'b1;
          send_home();
        end else begin
          put_side_ptr(on_start, v);
        end
      end
      FUNC_DIFF: begin
        size = fill_level();
        if (!c.index_in_valid) begin
          r.difference = CNT_W'(size);
        end else begin
          s = on_start ? v : int'(ring_start);
          e = on_start ? int'(ring_end) : v;
          size2 = ring_span(s, e);
          if (size2 > size) begin
            r.bigger = 1'b1;
            r.difference = CNT_W'(size2 - size);
          end else begin
            r.difference = CNT_W'(size - size2);
          end
        end
      end
      FUNC_HOME: send_home();
      default: ;
    endcase
    r.occupancy = CNT_W'(fill_level());
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  task automatic check_reply(input res_t got, input res_t want);
    if (got.index_out !== want.index_out)
      flag_mismatch("index_out", 32'(got.index_out), 32'(want.index_out));
    if (got.index_out_valid !== want.index_out_valid)
      flag_mismatch("index_out_valid", 32'(got.index_out_valid),
                    32'(want.index_out_valid));
    if (got.occupancy !== want.occupancy)
      flag_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
    if (got.difference !== want.difference)
      flag_mismatch("difference", 32'(got.difference), 32'(want.difference));
    if (got.bigger !== want.bigger)
      flag_mismatch("bigger", 32'(got.bigger), 32'(want.bigger));
  endtask

  // Predict on every accepted item, check on every accepted result
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (res_valid && res_ready) begin
        moved = 1'b1;
        if (pointer_replies.size() == 0) flag_mismatch("result with nothing pending", 0, 0);
        else check_reply(res_item, pointer_replies.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        apply_reg_write(cfg_index, cfg_data);
      end
      if (cmd_valid && cmd_ready) begin
        moved = 1'b1;
        pointer_replies.push_back(run_pointer_op(op_item));
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (steady_flow) res_ready <= 1'b1;
    else res_ready <= ($urandom_range(99) >= 14);
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic issue_op(input cmd_t c);
    if (!steady_flow) begin
      while ($urandom_range(99) < 14) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_valid <= 1'b1;
    op_item <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic go_quiet();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pointer_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DAT_W-1:0] cap, input logic down,
                          input bit with_spare);
    logic [CFG_DAT_W-1:0] down_word;
    down_word = {(CFG_DAT_W-1)'($urandom), down};
    go_quiet();
    if ($urandom_range(1)) begin
      write_reg(CFG_CAPACITY, cap);
      write_reg(CFG_DOWNWARD, down_word);
    end else begin
      write_reg(CFG_DOWNWARD, down_word);
      write_reg(CFG_CAPACITY, cap);
    end
    if (with_spare) write_reg($urandom_range(1) ? CFG_SPARE2 : CFG_SPARE3, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t make_op(input logic [2:0] func, input logic side,
                                   input int amount, input logic back,
                                   input int idx, input logic idx_ok);
    cmd_t c;
    c.func = func;
    c.which_side = side;
    c.amount = CNT_W'(amount);
    c.backward = back;
    c.index_in = IDX_W'(idx);
    c.index_in_valid = idx_ok;
    return c;
  endfunction

  // Random fields everywhere, then shape the ones the chosen operation uses
  function automatic cmd_t random_op();
    cmd_t c;
    int roll, cap;
    cap = slots_in_use();
    c = CMD_W'($urandom);
    c.which_side = ($urandom_range(99) < write_pct) ? WRITE_SIDE : READ_SIDE;
    roll = $urandom_range(99);
    if (roll < 38) begin
      c.func = FUNC_ADVANCE;
    end else if (roll < 53) begin
      c.func = FUNC_SKIP;
      if ($urandom_range(3) != 0) c.amount = CNT_W'($urandom_range(cap + 1));
    end else if (roll < 64) begin
      c.func = FUNC_GET;
    end else if (roll < 90) begin
      c.func = (roll < 76) ? FUNC_SET : FUNC_DIFF;
      c.index_in_valid = ($urandom_range(9) != 0);
      if ($urandom_range(3) != 0) c.index_in = IDX_W'($urandom_range(cap - 1));
    end else if (roll < 96) begin
      c.func = FUNC_HOME;
    end else begin
      c.func = $urandom_range(1) ? FUNC_SPARE6 : FUNC_SPARE7;
    end
    return c;
  endfunction

  // Fill first, then drain, so small rings hit both full and empty
  task automatic run_random_items(input int n);
    for (int i = 0; i < n; i++) begin
      write_pct = (i < n / 2) ? 65 : 35;
      if ($urandom_range(199) == 0) go_quiet();
      issue_op(random_op());
    end
  endtask

  task automatic test_corner_cases();
    issue_op(make_op(FUNC_ADVANCE, READ_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_GET, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_SKIP, READ_SIDE, 100, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_ADVANCE, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_ADVANCE, READ_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_SKIP, READ_SIDE, 8191, 1'b1, 0, 1'b0));
    issue_op(make_op(FUNC_ADVANCE, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_DIFF, WRITE_SIDE, 0, 1'b0, 4095, 1'b1));
    issue_op(make_op(FUNC_DIFF, READ_SIDE, 0, 1'b0, 4095, 1'b0));
    issue_op(make_op(FUNC_SKIP, READ_SIDE, 8191, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_SKIP, READ_SIDE, 0, 1'b1, 0, 1'b0));
    issue_op(make_op(FUNC_SET, WRITE_SIDE, 0, 1'b0, 4095, 1'b1));
    issue_op(make_op(FUNC_SET, READ_SIDE, 0, 1'b0, 0, 1'b1));
    issue_op(make_op(FUNC_SKIP, READ_SIDE, 1, 1'b1, 0, 1'b0));
    issue_op(make_op(FUNC_GET, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_SET, READ_SIDE, 0, 1'b0, 77, 1'b0));
    issue_op(make_op(FUNC_HOME, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_SPARE6, READ_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_SPARE7, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    // three-slot ring counting down: fill past full, clamp an index
    set_regs(CFG_DAT_W'(3), 1'b1, 1'b1);
    repeat (4) issue_op(make_op(FUNC_ADVANCE, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_SET, READ_SIDE, 0, 1'b0, 4095, 1'b1));
    issue_op(make_op(FUNC_DIFF, READ_SIDE, 0, 1'b0, 4095, 1'b1));
    // zero capacity behaves as a single slot
    set_regs('0, 1'b0, 1'b0);
    repeat (2) issue_op(make_op(FUNC_ADVANCE, WRITE_SIDE, 0, 1'b0, 0, 1'b0));
    issue_op(make_op(FUNC_ADVANCE, READ_SIDE, 0, 1'b0, 0, 1'b0));
  endtask

  task automatic test_config_sweep();
    logic [CFG_DAT_W-1:0] cap_val;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: cap_val = CFG_DAT_W'(1);
        1: cap_val = CFG_DAT_W'(2);
        2: cap_val = CFG_DAT_W'(3);
        3: cap_val = CFG_DAT_W'(4);
        4: cap_val = CFG_DAT_W'(7);
        5: cap_val = CFG_DAT_W'(16);
        6: cap_val = CFG_DAT_W'(255);
        7: cap_val = CFG_DAT_W'(4096);
        8: cap_val = CFG_DAT_W'(0);
        9: cap_val = CFG_DAT_W'(8191);
        10: cap_val = CFG_DAT_W'(4097);
        default: cap_val = CFG_DAT_W'($urandom_range(4096, 1));
      endcase
      set_regs(cap_val, ph[0], $urandom_range(3) == 0);
      run_random_items(105);
    end
  endtask

  task automatic test_steady_stream();
    steady_flow = 1'b1;
    set_regs(CFG_DAT_W'($urandom_range(64, 1)), 1'($urandom_range(1)), 1'b0);
    run_random_items(260);
    go_quiet();
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_config_sweep();
    test_steady_stream();
    go_quiet();
    if (pointer_replies.size() != 0)
      flag_mismatch("results never delivered", 0, pointer_replies.size());
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
